// ===== sv/scar_pkg.sv =====
`default_nettype none
package scar_pkg;

	// Fixed sample and internal formats
	localparam int SW = 16;
	localparam int IW = 24;
	localparam int FRAC_BITS = IW - 5;
	localparam int GAIN_W = 18;
	localparam int ACC_W = IW + GAIN_W + 1;
	localparam int IN_SHIFT = SW + 15 - FRAC_BITS;
	localparam int WET_SHIFT = FRAC_BITS + 16 - (SW - 1);
	localparam int Q16 = 16;
	localparam logic [GAIN_W-1:0] IN_GAIN = 18'd983;

	// Filter bank
	localparam int NCOMB = 8;
	localparam int NAP = 4;
	localparam int NTAP = 2 * NCOMB + 2 * NAP;
	localparam int TIDX_W = $clog2(NTAP);
	localparam int TAP_W = 11;
	localparam int COMB_SUM = 11024;
	localparam int AP_SUM = 1563;
	localparam logic [TAP_W-1:0] COMB_LEN [NCOMB] = '{
		11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617};
	localparam logic [TAP_W-1:0] AP_LEN [NAP] = '{11'd556, 11'd441, 11'd341, 11'd225};

	// Configuration registers
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WET = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PREDELAY = 2'd3;
	localparam logic [15:0] FEEDBACK_RST = 16'd55050;
	localparam logic [15:0] DAMPING_RST = 16'd13107;
	localparam int PDLEN_W = 14;

	localparam logic signed [ACC_W-1:0] INT_HI = (ACC_W'(1) << (IW - 1)) - 1'b1;
	localparam logic signed [ACC_W-1:0] INT_LO = ~INT_HI;
	localparam logic signed [ACC_W-1:0] SMP_HI = (ACC_W'(1) << (SW - 1)) - 1'b1;
	localparam logic signed [ACC_W-1:0] SMP_LO = ~SMP_HI;

	typedef struct packed {
		logic signed [SW-1:0] left_sample;
		logic signed [SW-1:0] right_sample;
		logic in_last;
	} in_item_t;

	typedef struct packed {
		logic signed [SW-1:0] left_wet;
		logic signed [SW-1:0] right_wet;
		logic out_last;
	} out_item_t;

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctl_t;

	// Round to nearest, half toward +inf, dropping d fraction bits
	function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
		input int d);
		logic signed [ACC_W-1:0] half;
		logic signed [ACC_W-1:0] s;
		half = '0;
		half[d-1] = 1'b1;
		s = v + half;
		rnd = s >>> d;
	endfunction

	function automatic logic signed [IW-1:0] sat_int(input logic signed [ACC_W-1:0] v);
		if (v > INT_HI) sat_int = INT_HI[IW-1:0];
		else if (v < INT_LO) sat_int = INT_LO[IW-1:0];
		else sat_int = v[IW-1:0];
	endfunction

	function automatic logic signed [SW-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
		if (v > SMP_HI) sat_smp = SMP_HI[SW-1:0];
		else if (v < SMP_LO) sat_smp = SMP_LO[SW-1:0];
		else sat_smp = v[SW-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] ext(input logic signed [IW-1:0] v);
		ext = v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/stereo_comb_allpass_reverb_top.sv =====
`default_nettype none
// Stereo reverb, wet output only. Each frame runs left then right through an optional
// pre-delay, a fixed input gain, 8 lowpass-feedback combs summed and 4 serial allpasses,
// then the wet gain with 16-bit saturation. All multiplications go through one shared
// 24x18 multiply-accumulate under a sequencer, and each comb or allpass tap is one
// access of a single-port-read delay memory. A frame is therefore taken, run through
// the left and then the right channel, and handed off to the output register; the
// block takes no new frame until that hand-off.
// A finished result sits in an output register, so the next frame can be taken while
// it waits; a frame that finishes while the previous result still waits holds until
// that one is taken. After reset the delay memories are zeroed one entry a cycle, and
// no frame is taken until the larger of the comb and pre-delay memories is cleared;
// configuration writes are taken at any time.
module stereo_comb_allpass_reverb_top #(
	parameter int MAX_PREDELAY = 9600,
	parameter int STEREO_SPREAD = 23
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire scar_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output scar_pkg::out_item_t out_data,
	input wire logic cfg_write,
	input wire logic [scar_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [scar_pkg::CFG_W-1:0] cfg_data
);
	localparam int IW = scar_pkg::IW;
	localparam int SW = scar_pkg::SW;
	localparam int ACC_W = scar_pkg::ACC_W;
	localparam int TAP_W = scar_pkg::TAP_W;
	localparam int SUM_W = IW + 3;
	localparam int COMB_DEPTH = 2 * scar_pkg::COMB_SUM + scar_pkg::NCOMB * STEREO_SPREAD;
	localparam int AP_DEPTH = 2 * scar_pkg::AP_SUM + scar_pkg::NAP * STEREO_SPREAD;
	localparam int PD_DEPTH = 2 * MAX_PREDELAY;
	localparam int CA_W = $clog2(COMB_DEPTH);
	localparam int AA_W = $clog2(AP_DEPTH);
	localparam int PA_W = $clog2(PD_DEPTH);
	localparam int PW = $clog2(MAX_PREDELAY + 1);
	localparam int CLR_N = (COMB_DEPTH > PD_DEPTH) ? COMB_DEPTH : PD_DEPTH;
	localparam int CLR_W = $clog2(CLR_N + 1);

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_PD = 5'd2;
	localparam logic [4:0] S_IN = 5'd3;
	localparam logic [4:0] S_INR = 5'd4;
	localparam logic [4:0] S_CRD = 5'd5;
	localparam logic [4:0] S_CM1 = 5'd6;
	localparam logic [4:0] S_CM2 = 5'd7;
	localparam logic [4:0] S_CM3 = 5'd8;
	localparam logic [4:0] S_CM4 = 5'd9;
	localparam logic [4:0] S_CM5 = 5'd10;
	localparam logic [4:0] S_ARD = 5'd11;
	localparam logic [4:0] S_AWR = 5'd12;
	localparam logic [4:0] S_WET = 5'd13;
	localparam logic [4:0] S_WETR = 5'd14;
	localparam logic [4:0] S_DONE = 5'd15;

	logic [4:0] state_q;
	logic [CLR_W-1:0] clr_q;
	logic ch_q;
	logic [2:0] i_q;
	scar_pkg::in_item_t in_q;
	logic [15:0] fb_q;
	logic [15:0] damp_q;
	logic [16:0] wet_q;
	logic [scar_pkg::PDLEN_W-1:0] pdlen_q;
	logic [PW-1:0] pos_q;
	logic signed [IW-1:0] x_q;
	logic signed [IW-1:0] st_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CA_W-1:0] cbase_q;
	logic [CA_W-1:0] caddr_q;
	logic [AA_W-1:0] abase_q;
	logic [AA_W-1:0] aaddr_q;
	logic [TAP_W-1:0] tap_q [scar_pkg::NTAP];
	logic signed [IW-1:0] lp_q [2*scar_pkg::NCOMB];
	logic signed [SW-1:0] res_l_q;
	logic signed [SW-1:0] res_r_q;
	scar_pkg::out_item_t out_q;
	logic out_valid_q;

	// Tap bookkeeping
	logic is_ap;
	logic [scar_pkg::TIDX_W-1:0] tap_idx;
	logic [3:0] lp_idx;
	logic [TAP_W-1:0] spread;
	logic [TAP_W-1:0] tap_len;
	logic [TAP_W-1:0] tap_p;
	logic [TAP_W-1:0] tap_next;

	assign is_ap = (state_q == S_ARD) || (state_q == S_AWR);
	assign lp_idx = {ch_q, i_q};
	assign tap_idx = is_ap ? scar_pkg::TIDX_W'(2 * scar_pkg::NCOMB) + {2'b00, ch_q, i_q[1:0]}
		: {1'b0, lp_idx};
	assign spread = ch_q ? TAP_W'(STEREO_SPREAD) : '0;
	assign tap_len = (is_ap ? scar_pkg::AP_LEN[i_q[1:0]] : scar_pkg::COMB_LEN[i_q]) + spread;
	assign tap_p = tap_q[tap_idx];
	assign tap_next = (({1'b0, tap_p} + 1'b1) >= {1'b0, tap_len}) ? '0 : TAP_W'(tap_p + 1'b1);

	// Pre-delay addressing
	logic [PW-1:0] pd_eff;
	logic [PW-1:0] pd_rd;
	logic [PA_W-1:0] pd_off;
	logic pd_on;

	assign pd_on = (pdlen_q != '0);
	assign pd_eff = (int'(pdlen_q) >= MAX_PREDELAY) ? PW'(MAX_PREDELAY - 1) : PW'(pdlen_q);
	assign pd_rd = (pos_q >= pd_eff) ? PW'(pos_q - pd_eff)
		: PW'(pos_q + PW'(MAX_PREDELAY) - pd_eff);
	assign pd_off = ch_q ? PA_W'(MAX_PREDELAY) : '0;

	// Memories
	logic c_we, a_we, p_we;
	logic [CA_W-1:0] c_waddr, c_raddr;
	logic [AA_W-1:0] a_waddr, a_raddr;
	logic [PA_W-1:0] p_waddr, p_raddr;
	logic [IW-1:0] c_wdata, c_rdata, a_wdata, a_rdata;
	logic [SW-1:0] p_wdata, p_rdata;

	scar_ram #(.WIDTH(IW), .DEPTH(COMB_DEPTH)) u_comb_ram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata));
	scar_ram #(.WIDTH(IW), .DEPTH(AP_DEPTH)) u_ap_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata));
	scar_ram #(.WIDTH(SW), .DEPTH(PD_DEPTH)) u_pd_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata));

	// Shared multiply-accumulate
	scar_pkg::mac_ctl_t mac_ctl;
	logic signed [IW-1:0] mac_a;
	logic signed [scar_pkg::GAIN_W-1:0] mac_b;
	logic signed [ACC_W-1:0] acc;

	scar_mac u_mac (.clk(clk), .ctl(mac_ctl), .a(mac_a), .b(mac_b), .acc(acc));

	logic signed [SW-1:0] ch_smp;
	logic signed [SW-1:0] pd_smp;
	logic signed [IW-1:0] comb_o;
	logic signed [IW-1:0] ap_b;
	logic signed [IW-1:0] sum24;
	logic signed [IW-1:0] in_x;
	logic signed [IW-1:0] st_c;
	logic signed [IW-1:0] cw_c;
	logic signed [IW-1:0] ap_w;
	logic signed [IW-1:0] ap_sum;
	logic signed [SW-1:0] wet_c;

	assign ch_smp = ch_q ? in_q.right_sample : in_q.left_sample;
	assign pd_smp = pd_on ? $signed(p_rdata) : ch_smp;
	assign comb_o = $signed(c_rdata);
	assign ap_b = $signed(a_rdata);
	assign sum24 = sum_q[IW-1:0];
	assign in_x = scar_pkg::sat_int(scar_pkg::rnd(acc, scar_pkg::IN_SHIFT));
	assign st_c = scar_pkg::sat_int(scar_pkg::rnd(acc, scar_pkg::Q16));
	assign cw_c = scar_pkg::sat_int(scar_pkg::ext(x_q) + scar_pkg::rnd(acc, scar_pkg::Q16));
	assign ap_w = scar_pkg::sat_int(scar_pkg::ext(sum24)
		+ scar_pkg::rnd(scar_pkg::ext(ap_b), 1));
	assign ap_sum = scar_pkg::sat_int(scar_pkg::ext(ap_b) - scar_pkg::ext(sum24));
	assign wet_c = scar_pkg::sat_smp(scar_pkg::rnd(acc, scar_pkg::WET_SHIFT));

	// Drive memory ports and the multiplier from the sequencer state
	always_comb begin
		c_we = 1'b0;
		a_we = 1'b0;
		p_we = 1'b0;
		c_waddr = caddr_q;
		a_waddr = aaddr_q;
		p_waddr = PA_W'(pos_q) + pd_off;
		c_wdata = cw_c;
		a_wdata = ap_w;
		p_wdata = ch_smp;
		c_raddr = cbase_q + CA_W'(tap_p);
		a_raddr = abase_q + AA_W'(tap_p);
		p_raddr = PA_W'(pd_rd) + pd_off;
		mac_ctl = '{en: 1'b0, clr: 1'b1};
		mac_a = comb_o;
		mac_b = $signed({2'b00, 16'h0000});
		case (state_q)
			S_CLEAR: begin
				c_we = (int'(clr_q) < COMB_DEPTH);
				a_we = (int'(clr_q) < AP_DEPTH);
				p_we = (int'(clr_q) < PD_DEPTH);
				c_waddr = clr_q[CA_W-1:0];
				a_waddr = clr_q[AA_W-1:0];
				p_waddr = clr_q[PA_W-1:0];
				c_wdata = '0;
				a_wdata = '0;
				p_wdata = '0;
			end
			S_PD: p_we = pd_on;
			S_IN: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a = IW'(pd_smp);
				mac_b = $signed(scar_pkg::IN_GAIN);
			end
			S_CM1: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a = comb_o;
				mac_b = $signed({1'b0, 17'(17'h10000 - {1'b0, damp_q})});
			end
			S_CM2: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0};
				mac_a = lp_q[lp_idx];
				mac_b = $signed({2'b00, damp_q});
			end
			S_CM4: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a = st_q;
				mac_b = $signed({2'b00, fb_q});
			end
			S_CM5: c_we = 1'b1;
			S_AWR: a_we = 1'b1;
			S_WET: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a = sum24;
				mac_b = $signed({1'b0, wet_q});
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q <= scar_pkg::FEEDBACK_RST;
			damp_q <= scar_pkg::DAMPING_RST;
			wet_q <= '0;
			pdlen_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				scar_pkg::REG_FEEDBACK: fb_q <= cfg_data[15:0];
				scar_pkg::REG_DAMPING: damp_q <= cfg_data[15:0];
				scar_pkg::REG_WET: wet_q <= cfg_data;
				scar_pkg::REG_PREDELAY: pdlen_q <= cfg_data[scar_pkg::PDLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			ch_q <= 1'b0;
			i_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < scar_pkg::NTAP; k++) tap_q[k] <= '0;
			for (int k = 0; k < 2 * scar_pkg::NCOMB; k++) lp_q[k] <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (int'(clr_q) == CLR_N - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						in_q <= in_data;
						ch_q <= 1'b0;
						cbase_q <= '0;
						abase_q <= '0;
						state_q <= S_PD;
					end
				end
				S_PD: state_q <= S_IN;
				S_IN: state_q <= S_INR;
				S_INR: begin
					x_q <= in_x;
					sum_q <= '0;
					i_q <= '0;
					state_q <= S_CRD;
				end
				S_CRD: begin
					caddr_q <= c_raddr;
					state_q <= S_CM1;
				end
				S_CM1: begin
					sum_q <= sum_q + SUM_W'(comb_o);
					state_q <= S_CM2;
				end
				S_CM2: state_q <= S_CM3;
				S_CM3: begin
					lp_q[lp_idx] <= st_c;
					st_q <= st_c;
					state_q <= S_CM4;
				end
				S_CM4: state_q <= S_CM5;
				S_CM5: begin
					tap_q[tap_idx] <= tap_next;
					cbase_q <= cbase_q + CA_W'(tap_len);
					if (i_q == 3'(scar_pkg::NCOMB - 1)) begin
						sum_q <= SUM_W'(scar_pkg::sat_int(ACC_W'(sum_q)));
						i_q <= '0;
						state_q <= S_ARD;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_CRD;
					end
				end
				S_ARD: begin
					aaddr_q <= a_raddr;
					state_q <= S_AWR;
				end
				S_AWR: begin
					tap_q[tap_idx] <= tap_next;
					abase_q <= abase_q + AA_W'(tap_len);
					sum_q <= SUM_W'(ap_sum);
					i_q <= i_q + 1'b1;
					if (i_q == 3'(scar_pkg::NAP - 1)) state_q <= S_WET;
					else state_q <= S_ARD;
				end
				S_WET: state_q <= S_WETR;
				S_WETR: begin
					if (!ch_q) begin
						res_l_q <= wet_c;
						ch_q <= 1'b1;
						state_q <= S_PD;
					end else begin
						res_r_q <= wet_c;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hand off once the output register is free
					if (!out_valid_q || out_ready) begin
						out_q.left_wet <= res_l_q;
						out_q.right_wet <= res_r_q;
						out_q.out_last <= in_q.in_last;
						out_valid_q <= 1'b1;
						pos_q <= (int'(pos_q) == MAX_PREDELAY - 1) ? '0 : PW'(pos_q + 1'b1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sequencer and handshake checks

	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CM5 || state_q == S_AWR) |-> tap_p < tap_len)
		else $error("delay tap beyond its line length");

	a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("frame taken during memory clear");

	a_start_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_PD && !ch_q))
		else $error("frame transfer did not start the left channel");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!out_valid_q || out_ready)) |=> out_valid_q)
		else $error("finished frame not presented");

endmodule
`default_nettype wire

// ===== sv/scar_ram.sv =====
`default_nettype none
module scar_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/scar_mac.sv =====
`default_nettype none
module scar_mac (
	input wire logic clk,
	input wire scar_pkg::mac_ctl_t ctl,
	input wire logic signed [scar_pkg::IW-1:0] a,
	input wire logic signed [scar_pkg::GAIN_W-1:0] b,
	output logic signed [scar_pkg::ACC_W-1:0] acc
);
	logic signed [scar_pkg::IW+scar_pkg::GAIN_W-1:0] prod;
	logic signed [scar_pkg::ACC_W-1:0] acc_q;

	assign prod = a * b;
	assign acc = acc_q;

	// Start a new sum or add onto the running one
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.clr) acc_q <= scar_pkg::ACC_W'(prod);
			else acc_q <= acc_q + scar_pkg::ACC_W'(prod);
		end
	end
endmodule
`default_nettype wire
